/* rtl/core/hash_set_linear_probing_unit_macros.svh */
// Assertion macros shared by the hash set RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HASH_SET_LINEAR_PROBING_UNIT_MACROS_SVH
`define HASH_SET_LINEAR_PROBING_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HSLP_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("hash set assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HSLP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("hash set assertion failed");

`endif

/* rtl/core/hslp_pkg.sv */
// Shared constants and types for the linear-probing hash set.
// Depends on nothing; imported by hslp_table and the top level.
`timescale 1ns / 1ps

package hslp_pkg;

   // Table size must be a power of two: the home slot is the key's low bits.
   localparam int SLOTS  = 1024;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int KEY_W  = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } tbl_rd_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         entry;
   } tbl_wr_type;

endpackage

/* rtl/core/hslp_table.sv */
// Slot table of the hash set: one synchronous memory, one write and one read port.
// Depends on hslp_pkg.
`timescale 1ns / 1ps

module hslp_table
   import hslp_pkg::*;
(
   input  logic       clock,
   input  tbl_rd_type rd,
   input  tbl_wr_type wr,
   output entry_type  rd_entry
);

   entry_type mem [SLOTS];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   // Read data holds between reads, so a stalled probe keeps its entry.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_entry_ff <= mem[rd.addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

/* rtl/core/hash_set_linear_probing_unit.sv */
// Top level of the linear-probing hash set of signed 32-bit keys.
// Depends on hslp_pkg, hslp_table and hash_set_linear_probing_unit_macros.svh.
`timescale 1ns / 1ps

// Each request either inserts a key (tuser = 0) or asks whether it is present
// (tuser = 1) and yields exactly one response with found and overflow flags.
// The home slot is the key's floored modulo by the table size, which for a
// power-of-two table is simply the key's low bits. The table sits in one
// synchronous memory with a single read port; each probe is one read of that
// memory, and the number of slots probed runs from 1 up to the table size of
// 1024. A request is taken only while no probe is running, but a finished
// response may still wait in the output register; a probe that ends while
// that register is full waits until it drains. After reset the block clears
// the valid bits of the table, one slot a cycle, and holds req_tready low
// during that pass. An insert into a full table is dropped and reported
// with overflow set; a query on a full table of other keys reports not
// found.

`include "hash_set_linear_probing_unit_macros.svh"

module hash_set_linear_probing_unit
   import hslp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] found, [1] overflow, [7:2] zero
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SLOT_W-1:0] addr_ff, addr_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic              ovf_ff, ovf_in;

   tbl_rd_type rd;
   tbl_wr_type wr;
   entry_type  rd_entry;

   logic              req_fire;
   logic              hit_empty;
   logic              hit_match;
   logic              last_probe;
   logic              probe_stop;
   logic              out_free;
   logic              probe_end;
   logic              probe_go;
   logic              insert_end;
   logic [SLOT_W-1:0] addr_step;

   hslp_table u_table (
      .clock    (clock),
      .rd       (rd),
      .wr       (wr),
      .rd_entry (rd_entry)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // The entry last read belongs to addr_ff while probing.
   assign hit_empty  = !rd_entry.valid;
   assign hit_match  = rd_entry.valid && (rd_entry.key == key_ff);
   assign last_probe = (cnt_ff == LAST_SLOT);
   assign probe_stop = hit_empty || hit_match || last_probe;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign probe_end  = (state_ff == ST_PROBE) && probe_stop && out_free;
   assign probe_go   = (state_ff == ST_PROBE) && !probe_stop;
   assign insert_end = probe_end && (op_ff == OP_INSERT);
   assign addr_step  = (addr_ff == LAST_SLOT) ? '0 : addr_ff + 1'b1;

   // A new request reads its home slot; a running probe reads the next slot.
   always_comb begin
      rd.en   = req_fire || probe_go;
      rd.addr = req_fire ? req_tdata[SLOT_W-1:0] : addr_step;
   end

   // The write of an insert lands before the next request can read, since
   // requests are taken only in the idle state that follows.
   always_comb begin
      wr.en        = 1'b0;
      wr.addr      = addr_ff;
      wr.entry     = '0;
      if (state_ff == ST_CLEAR) begin
         wr.en   = 1'b1;
         wr.addr = clr_ff;
      end else if (insert_end && hit_empty) begin
         wr.en          = 1'b1;
         wr.entry.valid = 1'b1;
         wr.entry.key   = key_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_tuser[0];
               key_in   = req_tdata;
               addr_in  = req_tdata[SLOT_W-1:0];
               cnt_in   = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!probe_stop) begin
               addr_in = addr_step;
               cnt_in  = cnt_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               found_in     = hit_match;
               ovf_in       = (op_ff == OP_INSERT) && !hit_empty && !hit_match;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      addr_ff  <= addr_in;
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, ovf_ff, found_ff};

   // A fresh response only ever follows the end of a probe.
   `HSLP_ASSERT_IMPL(a_rsp_after_probe, clock, reset, $rose(rsp_valid_ff), $past(probe_end))
   // A response never reports both a hit and an overflow.
   `HSLP_ASSERT_IMPL(a_flags_exclusive, clock, reset, rsp_valid_ff, !(found_ff && ovf_ff))
   // The table is written only by the clearing pass or by an insert at probe end.
   `HSLP_ASSERT_IMPL(a_write_source, clock, reset, wr.en, (state_ff == ST_CLEAR) || insert_end)
   // A probe that goes on stays in the probe state.
   `HSLP_ASSERT_NEXT(a_probe_stays, clock, reset, probe_go, state_ff == ST_PROBE)
   // A probe that goes on advances its count by one slot.
   `HSLP_ASSERT_NEXT(a_probe_count, clock, reset, probe_go, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule
